// ===== rtl/core/ksb_pkg.sv =====
// Shared types and constants for the keyed slot buffer.
// Holds the transfer payload structs, the token that walks the cell chain and the codes.
// Depends on nothing; every other file in rtl/core imports it.
package ksb_pkg;

    localparam int SLOTS = 16;

    localparam int OP_ID_W   = 16;
    localparam int ID_W      = 8;
    localparam int PAYLOAD_W = 32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Operation codes.
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_READ  = 1'b1;

    // Key selection codes.
    localparam logic KEY_CLIENT = 1'b0;
    localparam logic KEY_ENTERP = 1'b1;

    // Register index of key_select (taken from the word address).
    localparam logic REG_KEY_SELECT = 1'b0;

    localparam logic [OP_ID_W-1:0] NO_OP_ID = {OP_ID_W{1'b1}};

    typedef struct packed {
        logic                 opcode;
        logic [OP_ID_W-1:0]   op_id;
        logic [ID_W-1:0]      client;
        logic [ID_W-1:0]      enterp;
        logic [PAYLOAD_W-1:0] payload;
        logic [ID_W-1:0]      read_key;
    } in_t;

    typedef struct packed {
        logic                 accepted;
        logic                 found;
        logic [OP_ID_W-1:0]   out_op_id;
        logic [ID_W-1:0]      out_client;
        logic [ID_W-1:0]      out_enterp;
        logic [PAYLOAD_W-1:0] out_payload;
    } out_t;

    typedef struct packed {
        logic [OP_ID_W-1:0]   op_id;
        logic [ID_W-1:0]      client;
        logic [ID_W-1:0]      enterp;
        logic [PAYLOAD_W-1:0] payload;
    } rec_t;

    // Request token handed from cell to cell. Once a cell serves the request,
    // done is set and later cells leave the token alone.
    typedef struct packed {
        logic            valid;
        logic            opcode;
        logic            done;
        logic [ID_W-1:0] key;
        rec_t            rec;
    } tok_t;

endpackage

// ===== rtl/core/ksb_cfg.sv =====
// Configuration register block of the keyed slot buffer: APB-style port, key_select.
// Depends on ksb_pkg.
module ksb_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ksb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ksb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ksb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic                           key_select
);
    import ksb_pkg::*;

    logic key_select_reg;
    logic key_select_next;
    logic wr_en;
    logic hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1] == REG_KEY_SELECT);
    assign wr_en  = psel && penable && pwrite && pready && hit;

    always_comb begin
        key_select_next = key_select_reg;
        if (wr_en) begin
            key_select_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_select_reg <= KEY_CLIENT;
        end else begin
            key_select_reg <= key_select_next;
        end
    end

    assign prdata     = hit ? {{(APB_DATA_W-1){1'b0}}, key_select_reg} : '0;
    assign key_select = key_select_reg;

endmodule

// ===== rtl/core/ksb_cell.sv =====
// One slot of the keyed slot buffer: used mark, stored record and a token stage.
// Depends on ksb_pkg.
module ksb_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          key_select,
    input  ksb_pkg::tok_t tok_in,
    output ksb_pkg::tok_t tok_out
);
    import ksb_pkg::*;

    logic            used_reg;
    logic            used_next;
    rec_t            rec_reg;
    tok_t            tok_reg;
    tok_t            tok_next;
    logic [ID_W-1:0] slot_key;
    logic            take_write;
    logic            take_read;

    assign slot_key = (key_select == KEY_ENTERP) ? rec_reg.enterp : rec_reg.client;

    assign take_write = tok_in.valid && (tok_in.opcode == OPC_WRITE) && !tok_in.done
                        && !used_reg;
    assign take_read  = tok_in.valid && (tok_in.opcode == OPC_READ) && !tok_in.done
                        && used_reg && (slot_key == tok_in.key);

    always_comb begin
        tok_next  = tok_in;
        used_next = used_reg;
        if (take_write) begin
            tok_next.done = 1'b1;
            used_next     = 1'b1;
        end else if (take_read) begin
            tok_next.done = 1'b1;
            tok_next.rec  = rec_reg;
            used_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && take_write) begin
            rec_reg <= tok_in.rec;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/keyed_slot_buffer_top.sv =====
// Keyed slot buffer top level. A request walks the chain of SLOTS (16) slot cells, one cell
// per cycle, and its result is presented from the last cell's token register. Throughput
// is one item per cycle; the whole chain holds while a result waits on m_ready. Reset
// (aresetn low at a clock edge) frees every slot, empties the chain and clears key_select
// to zero. No clearing pass is needed; items are taken right after reset.
module keyed_slot_buffer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ksb_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ksb_pkg::out_t                  m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ksb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ksb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ksb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ksb_pkg::*;

    // The table is a row of SLOTS cells. Cell i owns slot i. A request enters
    // cell 0 as a token and moves one cell per cycle toward the last cell while
    // the chain advances. The first cell that can serve it (a free slot for a
    // write, a used slot with a matching key for a read) does so and marks the
    // token done, so the lowest slot always wins. Tokens never pass each other,
    // so every request sees the table exactly as all earlier requests left it.

    logic key_select;
    logic adv;
    tok_t tok_head;
    tok_t tok_chain [SLOTS+1];
    tok_t tok_last;

    ksb_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .key_select (key_select)
    );

    // The chain moves as a whole whenever the last stage is empty or its
    // result transfer completes in this cycle.
    assign adv     = !tok_last.valid || m_ready;
    assign s_ready = adv;

    always_comb begin
        tok_head.valid       = s_valid;
        tok_head.opcode      = s_data.opcode;
        tok_head.done        = 1'b0;
        tok_head.key         = s_data.read_key;
        tok_head.rec.op_id   = s_data.op_id;
        tok_head.rec.client  = s_data.client;
        tok_head.rec.enterp  = s_data.enterp;
        tok_head.rec.payload = s_data.payload;
    end

    assign tok_chain[0] = tok_head;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        ksb_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .key_select (key_select),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1])
        );
    end

    assign tok_last = tok_chain[SLOTS];
    assign m_valid  = tok_last.valid;

    // The last cell's token register is the output register. A write reports
    // only whether it was stored. A read that no slot served returns the
    // "no operation" id with all other fields zero.
    always_comb begin
        m_data = '0;
        case (tok_last.opcode)
            OPC_WRITE: begin
                m_data.accepted = tok_last.done;
            end
            OPC_READ: begin
                m_data.found = tok_last.done;
                if (tok_last.done) begin
                    m_data.out_op_id   = tok_last.rec.op_id;
                    m_data.out_client  = tok_last.rec.client;
                    m_data.out_enterp  = tok_last.rec.enterp;
                    m_data.out_payload = tok_last.rec.payload;
                end else begin
                    m_data.out_op_id = NO_OP_ID;
                end
            end
            default: begin
                m_data = '0;
            end
        endcase
    end

endmodule
